>>> sv/bpc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpc_pkg
// Types and constants shared by the button press classifier: word layouts,
// debounced state codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package bpc_pkg;

	// debounced state codes
	localparam logic [2:0] ST_UNKNOWN  = 3'd0;
	localparam logic [2:0] ST_RELEASED = 3'd1;
	localparam logic [2:0] ST_PRESSED  = 3'd2;
	localparam logic [2:0] ST_SHORT    = 3'd3;
	localparam logic [2:0] ST_LONG     = 3'd4;

	// configuration register indexes
	localparam logic [1:0] REG_DEBOUNCE   = 2'd0;
	localparam logic [1:0] REG_LONG_PRESS = 2'd1;
	localparam logic [1:0] REG_ENABLE     = 2'd2;

	// configuration reset values
	localparam logic [31:0] DEBOUNCE_RST   = 32'd50000;
	localparam logic [31:0] LONG_PRESS_RST = 32'd3000000;
	localparam logic [7:0]  ENABLE_RST     = 8'd3;

	// input word: one poll sample
	typedef struct packed {
		logic [2:0]  button_index;
		logic        pin_level;
		logic [31:0] now_time;
	} in_word_t;

	// output word: classification of one sample
	typedef struct packed {
		logic [2:0]  out_index;
		logic [2:0]  press_state;
		logic [31:0] press_duration;
		logic        state_changed;
	} out_word_t;

endpackage
`default_nettype wire

>>> sv/button_press_classifier.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// button_press_classifier
// Debounces poll samples of up to eight buttons and classifies each button
// as released, pressed, short press or long press, with press durations.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+---------------------------
//  in      | input     | in_valid / in_stall     | in_word  (bpc_pkg::in_word_t)
//  out     | output    | out_valid / out_stall   | out_word (bpc_pkg::out_word_t)
//  cfg     | input     | cfg_wr_en               | cfg_index, cfg_data
//
//  One word per cycle while the output is not stalled; a word passes the input
//  register, then the result register, on its way to the output.
//  The per-button state is read and rewritten between the
//  two registers, so back-to-back samples of the same button see each other.
//  Reset clears all button state and loads the register defaults at once.
//  A stalled output holds its word; the input stalls only when the input
//  register is full and the full result register is stalled.
//
module button_press_classifier #(
	parameter int NUM_BUTTONS = 8
) (
	input  wire                  clk,
	input  wire                  arst_n,

	input  wire                  in_valid,
	output logic                 in_stall,
	input  bpc_pkg::in_word_t    in_word,

	output logic                 out_valid,
	input  wire                  out_stall,
	output bpc_pkg::out_word_t   out_word,

	input  wire                  cfg_wr_en,
	input  wire  [1:0]           cfg_index,
	input  wire  [31:0]          cfg_data
);

	// only eight buttons can be addressed by the 3-bit index
	localparam int DEPTH = (NUM_BUTTONS < 8) ? NUM_BUTTONS : 8;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	// configuration registers
	logic [31:0] debounce_time_q;
	logic [31:0] long_press_time_q;
	logic [7:0]  input_enable_mask_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_time_q     <= bpc_pkg::DEBOUNCE_RST;
			long_press_time_q   <= bpc_pkg::LONG_PRESS_RST;
			input_enable_mask_q <= bpc_pkg::ENABLE_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				bpc_pkg::REG_DEBOUNCE:   debounce_time_q     <= cfg_data;
				bpc_pkg::REG_LONG_PRESS: long_press_time_q   <= cfg_data;
				bpc_pkg::REG_ENABLE:     input_enable_mask_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// input register and flow control
	logic              item_valid_s1;
	bpc_pkg::in_word_t item_s1;
	logic              out_valid_q;
	bpc_pkg::out_word_t out_word_q;
	logic              advance;

	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = item_valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			item_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_word;
		end
	end

	// per-button state
	logic [2:0]  debounced_state_q [DEPTH];
	logic [2:0]  raw_state_q       [DEPTH];
	logic [31:0] press_start_q     [DEPTH];
	logic [31:0] release_start_q   [DEPTH];
	logic [31:0] last_duration_q   [DEPTH];

	// read current entry
	logic             in_range;
	logic             enabled;
	logic [IDX_W-1:0] ent;
	logic [2:0]       cur_db, cur_raw;
	logic [31:0]      cur_ps, cur_rs, cur_ld;

	assign in_range = int'(item_s1.button_index) < NUM_BUTTONS;
	assign enabled  = in_range && input_enable_mask_q[item_s1.button_index];
	assign ent      = item_s1.button_index[IDX_W-1:0];

	always_comb begin
		if (in_range) begin
			cur_db  = debounced_state_q[ent];
			cur_raw = raw_state_q[ent];
			cur_ps  = press_start_q[ent];
			cur_rs  = release_start_q[ent];
			cur_ld  = last_duration_q[ent];
		end else begin
			cur_db  = bpc_pkg::ST_UNKNOWN;
			cur_raw = bpc_pkg::ST_UNKNOWN;
			cur_ps  = '0;
			cur_rs  = '0;
			cur_ld  = '0;
		end
	end

	// elapsed times, all modulo 2^32
	logic [31:0] since_release, since_press, held_time;
	logic        release_ok, short_ok, long_ok;

	assign since_release = item_s1.now_time - cur_rs;
	assign since_press   = item_s1.now_time - cur_ps;
	assign held_time     = cur_rs - cur_ps;
	assign release_ok    = since_release > debounce_time_q;
	assign short_ok      = since_press >= debounce_time_q;
	assign long_ok       = since_press >= long_press_time_q;

	// next state of the addressed button
	logic [2:0]  nxt_db, nxt_raw;
	logic [31:0] nxt_ps, nxt_rs, nxt_ld;
	logic        lvl;

	assign lvl = item_s1.pin_level;

	always_comb begin
		nxt_db  = cur_db;
		nxt_raw = cur_raw;
		nxt_ps  = cur_ps;
		nxt_rs  = cur_rs;
		nxt_ld  = cur_ld;
		if (enabled) begin
			unique case (cur_db)
				bpc_pkg::ST_UNKNOWN,
				bpc_pkg::ST_RELEASED: begin
					if (lvl) begin
						nxt_db  = bpc_pkg::ST_PRESSED;
						nxt_raw = bpc_pkg::ST_PRESSED;
						nxt_ps  = item_s1.now_time;
					end else begin
						nxt_db = bpc_pkg::ST_RELEASED;
						nxt_rs = item_s1.now_time;
						if (cur_db == bpc_pkg::ST_UNKNOWN) begin
							nxt_raw = bpc_pkg::ST_RELEASED;
						end
					end
				end
				bpc_pkg::ST_PRESSED,
				bpc_pkg::ST_SHORT,
				bpc_pkg::ST_LONG: begin
					if (!lvl) begin
						// release timing, accepted once it outlasts debounce
						if (cur_raw != bpc_pkg::ST_RELEASED) begin
							nxt_rs  = item_s1.now_time;
							nxt_raw = bpc_pkg::ST_RELEASED;
						end else if (release_ok) begin
							nxt_db = bpc_pkg::ST_RELEASED;
							nxt_ld = held_time;
						end
					end else if (cur_db == bpc_pkg::ST_PRESSED && short_ok) begin
						nxt_db  = bpc_pkg::ST_SHORT;
						nxt_raw = bpc_pkg::ST_SHORT;
					end else if (cur_db == bpc_pkg::ST_SHORT && long_ok) begin
						nxt_db  = bpc_pkg::ST_LONG;
						nxt_raw = bpc_pkg::ST_LONG;
					end
				end
				default: begin
					nxt_db = bpc_pkg::ST_UNKNOWN;
				end
			endcase
		end
	end

	// state write-back
	logic fire;

	assign fire = item_valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) begin
				debounced_state_q[i] <= bpc_pkg::ST_UNKNOWN;
				raw_state_q[i]       <= bpc_pkg::ST_UNKNOWN;
				press_start_q[i]     <= '0;
				release_start_q[i]   <= '0;
				last_duration_q[i]   <= '0;
			end
		end else if (fire && in_range) begin
			debounced_state_q[ent] <= nxt_db;
			raw_state_q[ent]       <= nxt_raw;
			press_start_q[ent]     <= nxt_ps;
			release_start_q[ent]   <= nxt_rs;
			last_duration_q[ent]   <= nxt_ld;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= item_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_word_q.out_index      <= item_s1.button_index;
			out_word_q.press_state    <= nxt_db;
			out_word_q.press_duration <= nxt_ld;
			out_word_q.state_changed  <= in_range && (nxt_db != cur_db);
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

	// checks
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> item_valid_s1 && out_valid_q)
		else $error("input stalled without a held word");

	a_fire_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> out_valid_q)
		else $error("processed word did not reach the result register");

	a_state_code_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_word_q.press_state <= bpc_pkg::ST_LONG)
		else $error("result carries an unused state code");

	a_out_of_range_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && int'(out_word_q.out_index) >= NUM_BUTTONS) |->
		(out_word_q.press_state == bpc_pkg::ST_UNKNOWN && !out_word_q.state_changed
		&& out_word_q.press_duration == '0))
		else $error("result for a missing button is not blank");

endmodule
`default_nettype wire

>>> dv/button_press_classifier_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_press_classifier_tb
// Drives poll samples into the button press classifier and predicts the
// debounced state, press duration and change flag of every sample with an
// in-house model of the per-button state. Covers directed corner cases,
// register extremes, long random press/release sequences and backpressure.
// ----------------------------------------------------------------------------
module button_press_classifier_tb;

	localparam int CYCLE_LIMIT = 600000;
	localparam int DRAIN_LIMIT = 20000;
	localparam int PHASE_ITEMS = 275;

	// clock and reset
	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// block ports
	logic                in_valid = 1'b0;
	logic                in_stall;
	bpc_pkg::in_word_t   in_word = '0;
	logic                out_valid;
	logic                out_stall = 1'b1;
	bpc_pkg::out_word_t  out_word;
	logic                cfg_wr_en = 1'b0;
	logic [1:0]          cfg_index = bpc_pkg::REG_DEBOUNCE;
	logic [31:0]         cfg_data = '0;

	// model of the register file
	logic [31:0] debounce_us   = bpc_pkg::DEBOUNCE_RST;
	logic [31:0] long_press_us = bpc_pkg::LONG_PRESS_RST;
	logic [7:0]  enable_mask   = bpc_pkg::ENABLE_RST;

	// model of the per-button state
	logic [2:0]  btn_state    [8] = '{default: bpc_pkg::ST_UNKNOWN};
	logic [2:0]  release_mark [8] = '{default: bpc_pkg::ST_UNKNOWN};
	logic [31:0] press_t0     [8] = '{default: 32'd0};
	logic [31:0] release_t0   [8] = '{default: 32'd0};
	logic [31:0] press_len    [8] = '{default: 32'd0};

	// classifications waiting for their output word
	bpc_pkg::out_word_t expected_results[$];

	// sender and receiver pacing
	int   error_count   = 0;
	int   cycle_count   = 0;
	int   hold_off_left = 0;
	int   stall_mode    = 0;
	int   stall_mode_left = 0;
	logic stall_flip    = 1'b0;
	bit   sender_gaps   = 1'b1;
	int   burst_left    = 4;

	// random sequence state: global microsecond clock and intended pin levels
	logic [31:0] now_us = '0;
	logic        held_level [8] = '{default: 1'b0};

	button_press_classifier #(
		.NUM_BUTTONS(8)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_word  (in_word),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_word (out_word),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// receiver stall pattern, with long hold-offs on request
	always @(posedge clk) begin
		if (hold_off_left > 0) begin
			out_stall <= 1'b1;
			hold_off_left--;
		end else begin
			if (stall_mode_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				stall_mode_left = $urandom_range(20, 200);
			end
			stall_mode_left--;
			stall_flip = ~stall_flip;
			case (stall_mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 3) == 0);
				2: out_stall <= ($urandom_range(0, 9) < 7);
				default: out_stall <= stall_flip;
			endcase
		end
	end

	// compare each output word with the oldest prediction
	always @(posedge clk) begin
		bpc_pkg::out_word_t exp_w;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				$error("unexpected output word: index %0d state %0d", out_word.out_index,
					out_word.press_state);
				error_count++;
			end else begin
				exp_w = expected_results.pop_front();
				if (out_word.out_index !== exp_w.out_index) begin
					$error("out_index: expected %0d, got %0d", exp_w.out_index,
						out_word.out_index);
					error_count++;
				end
				if (out_word.press_state !== exp_w.press_state) begin
					$error("press_state: expected %0d, got %0d", exp_w.press_state,
						out_word.press_state);
					error_count++;
				end
				if (out_word.press_duration !== exp_w.press_duration) begin
					$error("press_duration: expected %0d, got %0d", exp_w.press_duration,
						out_word.press_duration);
					error_count++;
				end
				if (out_word.state_changed !== exp_w.state_changed) begin
					$error("state_changed: expected %0d, got %0d", exp_w.state_changed,
						out_word.state_changed);
					error_count++;
				end
			end
		end
	end

	// press begins: debounced and raw state to pressed, timestamp the start
	function automatic void begin_press(input logic [2:0] b, input logic [31:0] t);
		btn_state[b]    = bpc_pkg::ST_PRESSED;
		release_mark[b] = bpc_pkg::ST_PRESSED;
		press_t0[b]     = t;
	endfunction

	// pin low while pressed: start timing, or accept after the debounce time
	function automatic void time_release(input logic [2:0] b, input logic [31:0] t);
		logic [31:0] elapsed;
		elapsed = t - release_t0[b];
		if (release_mark[b] != bpc_pkg::ST_RELEASED) begin
			release_t0[b]   = t;
			release_mark[b] = bpc_pkg::ST_RELEASED;
		end else if (elapsed > debounce_us) begin
			btn_state[b] = bpc_pkg::ST_RELEASED;
			press_len[b] = release_t0[b] - press_t0[b];
		end
	endfunction

	// classify one poll sample and advance the button's state
	function automatic bpc_pkg::out_word_t classify_sample(input bpc_pkg::in_word_t w);
		bpc_pkg::out_word_t r;
		logic [2:0]  b;
		logic [2:0]  prior;
		logic [31:0] held_for;
		b = w.button_index;
		prior = btn_state[b];
		held_for = w.now_time - press_t0[b];
		if (enable_mask[b]) begin
			case (btn_state[b])
				bpc_pkg::ST_UNKNOWN: begin
					if (w.pin_level) begin
						begin_press(b, w.now_time);
					end else begin
						btn_state[b]    = bpc_pkg::ST_RELEASED;
						release_mark[b] = bpc_pkg::ST_RELEASED;
						release_t0[b]   = w.now_time;
					end
				end
				bpc_pkg::ST_RELEASED: begin
					if (w.pin_level)
						begin_press(b, w.now_time);
					else
						release_t0[b] = w.now_time;
				end
				bpc_pkg::ST_PRESSED: begin
					if (!w.pin_level) begin
						time_release(b, w.now_time);
					end else if (held_for >= debounce_us) begin
						btn_state[b]    = bpc_pkg::ST_SHORT;
						release_mark[b] = bpc_pkg::ST_SHORT;
					end
				end
				bpc_pkg::ST_SHORT: begin
					if (!w.pin_level) begin
						time_release(b, w.now_time);
					end else if (held_for >= long_press_us) begin
						btn_state[b]    = bpc_pkg::ST_LONG;
						release_mark[b] = bpc_pkg::ST_LONG;
					end
				end
				bpc_pkg::ST_LONG: begin
					if (!w.pin_level)
						time_release(b, w.now_time);
				end
				default: btn_state[b] = bpc_pkg::ST_UNKNOWN;
			endcase
		end
		r.out_index      = b;
		r.press_state    = btn_state[b];
		r.press_duration = press_len[b];
		r.state_changed  = (btn_state[b] != prior);
		return r;
	endfunction

	// offer one sample word, record its prediction once taken
	task automatic send_sample(input logic [2:0] idx, input logic lvl, input logic [31:0] t);
		bpc_pkg::in_word_t w;
		w.button_index = idx;
		w.pin_level    = lvl;
		w.now_time     = t;
		in_valid <= 1'b1;
		in_word  <= w;
		do @(posedge clk); while (in_stall);
		expected_results.push_back(classify_sample(w));
		if (sender_gaps) begin
			burst_left--;
			if (burst_left <= 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
				burst_left = $urandom_range(1, 10);
			end
		end
	endtask

	// stop sending and let every predicted word come out
	task automatic wait_drained();
		in_valid <= 1'b0;
		for (int i = 0; i < DRAIN_LIMIT && expected_results.size() != 0; i++)
			@(posedge clk);
	endtask

	// program all three registers while the block is idle
	task automatic write_settings(input logic [31:0] deb, input logic [31:0] lp,
			input logic [31:0] mask_word);
		wait_drained();
		cfg_wr_en <= 1'b1;
		cfg_index <= bpc_pkg::REG_DEBOUNCE;
		cfg_data  <= deb;
		@(posedge clk);
		cfg_index <= bpc_pkg::REG_LONG_PRESS;
		cfg_data  <= lp;
		@(posedge clk);
		cfg_index <= bpc_pkg::REG_ENABLE;
		cfg_data  <= mask_word;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		debounce_us   = deb;
		long_press_us = lp;
		enable_mask   = mask_word[7:0];
	endtask

	// mostly press/hold/release sequences on a running clock, some raw noise
	task automatic send_random_samples(input int count, input int step_max);
		logic [2:0]  b;
		logic        lvl;
		logic [31:0] t;
		for (int n = 0; n < count; n++) begin
			b = 3'($urandom_range(0, 7));
			if ($urandom_range(0, 99) < 88) begin
				now_us = now_us + $urandom_range(0, step_max);
				if ($urandom_range(0, 5) == 0)
					held_level[b] = ~held_level[b];
				lvl = held_level[b];
				// contact bounce for a single sample
				if ($urandom_range(0, 11) == 0)
					lvl = ~lvl;
				t = now_us;
			end else begin
				lvl = 1'($urandom_range(0, 1));
				t = $urandom();
			end
			send_sample(b, lvl, t);
		end
	endtask

	// reset register values: full press cycles, wrap, disabled buttons
	task automatic test_reset_defaults();
		send_sample(3'd7, 1'b1, 32'd0);             // disabled: stays unknown
		send_sample(3'd0, 1'b0, 32'd0);             // unknown to released
		send_sample(3'd0, 1'b0, 32'd100);
		send_sample(3'd0, 1'b1, 32'd1000);          // pressed
		send_sample(3'd0, 1'b1, 32'd50999);         // one short of debounce
		send_sample(3'd0, 1'b1, 32'd51000);         // short press
		send_sample(3'd0, 1'b0, 32'd60000);         // release timing starts
		send_sample(3'd0, 1'b1, 32'd70000);         // bounce back high
		send_sample(3'd0, 1'b0, 32'd110000);        // exactly debounce: not yet
		send_sample(3'd0, 1'b0, 32'd110001);        // released, duration recorded
		send_sample(3'd1, 1'b1, 32'hFFFF_FFF0);     // press just before wrap
		send_sample(3'd1, 1'b1, 32'h0000_0010);     // wrapped, still pressed
		send_sample(3'd1, 1'b1, 32'd60000);         // short press
		send_sample(3'd1, 1'b1, 32'd2999990);       // long press after wrap
		send_sample(3'd1, 1'b1, 32'hFFFF_FFFF);     // long held
		send_sample(3'd1, 1'b0, 32'd3100000);
		send_sample(3'd1, 1'b0, 32'd3200000);       // released
		send_sample(3'd1, 1'b1, 32'd3300000);       // pressed again
		send_sample(3'd1, 1'b0, 32'd3300010);       // release timing starts again
	endtask

	// zero and all-ones timings, full and empty enable masks
	task automatic test_register_extremes();
		write_settings(32'd0, 32'd0, 32'h0000_00FF);
		send_sample(3'd2, 1'b1, 32'd100);           // pressed
		send_sample(3'd2, 1'b1, 32'd100);           // short at once
		send_sample(3'd2, 1'b1, 32'd100);           // long at once
		send_sample(3'd2, 1'b0, 32'd200);
		send_sample(3'd2, 1'b0, 32'd200);           // zero elapsed is not longer
		send_sample(3'd2, 1'b0, 32'd201);           // released
		send_sample(3'd7, 1'b0, 32'd0);
		send_sample(3'd7, 1'b1, 32'hFFFF_FFFF);
		write_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_sample(3'd3, 1'b1, 32'd10);
		send_sample(3'd3, 1'b1, 32'd8);             // one short of the full range
		send_sample(3'd3, 1'b1, 32'd9);             // short
		send_sample(3'd3, 1'b1, 32'd9);             // long
		send_sample(3'd3, 1'b0, 32'd20);
		send_sample(3'd3, 1'b0, 32'd19);            // release can never be accepted
		send_sample(3'd4, 1'b0, 32'd5);
		// upper data bits must not leak into the mask
		write_settings(32'd10, 32'd20, 32'hFFFF_FF00);
		send_sample(3'd0, 1'b1, 32'd0);
		send_sample(3'd3, 1'b1, 32'd1000);
		send_sample(3'd5, 1'b0, 32'd77);
	endtask

	// random sequences under a spread of register settings
	task automatic test_random_sequences();
		logic [31:0] deb;
		logic [31:0] lp;
		logic [31:0] mask_word;
		int          step;
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: begin deb = 32'd20; lp = 32'd150; mask_word = 32'hFF; step = 15; end
				1: begin deb = 32'd0; lp = 32'd40; mask_word = $urandom(); step = 10; end
				2: begin
					deb = $urandom_range(1, 60);
					lp = $urandom_range(60, 400);
					mask_word = 32'hFF;
					step = 30;
				end
				3: begin deb = 32'd5; lp = 32'd0; mask_word = 32'h5A; step = 8; end
				4: begin
					deb = 32'hFFFF_FFFF;
					lp = $urandom();
					mask_word = $urandom();
					step = 32'h7FFF_FFFF;
				end
				default: begin
					deb = bpc_pkg::DEBOUNCE_RST;
					lp = bpc_pkg::LONG_PRESS_RST;
					mask_word = 32'hFF;
					step = 20000;
				end
			endcase
			write_settings(deb, lp, mask_word);
			sender_gaps = (phase != 1);
			now_us = (phase == 2) ? 32'hFFFF_F000 : $urandom();
			send_random_samples(PHASE_ITEMS, step);
		end
		sender_gaps = 1'b1;
	endtask

	// receiver holds off while the sender keeps offering, then a full pause
	task automatic test_backpressure();
		write_settings(32'd12, 32'd90, 32'hFF);
		hold_off_left = 300;
		sender_gaps = 1'b0;
		send_random_samples(40, 6);
		wait_drained();
		sender_gaps = 1'b1;
		send_random_samples(60, 6);
		wait_drained();
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_register_extremes();
		test_random_sequences();
		test_backpressure();
		wait_drained();
		repeat (10) @(posedge clk);
		if (expected_results.size() != 0) begin
			$error("%0d predicted words never came out", expected_results.size());
			error_count++;
		end
		if (error_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
